// ===== rtl/sat_pkg.sv =====
// Shared constants, types and helpers of the segment address translator.
`default_nettype none
package sat_pkg;

	localparam int PROC_SLOTS   = 32;
	localparam int CLICK_BITS   = 4;
	localparam int NUM_SEGMENTS = 3;
	localparam int SLOT_W       = $clog2(PROC_SLOTS);
	localparam int ENTRY_W      = 48;
	localparam int ROW_W        = NUM_SEGMENTS * ENTRY_W;

	localparam logic       KIND_LOAD   = 1'b0;
	localparam logic       KIND_XLATE  = 1'b1;
	localparam logic [1:0] SEG_TEXT    = 2'd0;
	localparam logic [1:0] SEG_DATA    = 2'd1;
	localparam logic [1:0] SEG_STACK   = 2'd2;

	typedef logic [SLOT_W-1:0]       slot_t;
	typedef logic [NUM_SEGMENTS-1:0] lane_t;
	typedef logic [ROW_W-1:0]        row_t;

	typedef struct packed {
		logic [15:0] vbase;
		logic [15:0] len;
		logic [15:0] pbase;
	} seg_entry_t;

	typedef struct packed {
		logic        valid;
		logic        fault;
		logic        text;
		logic [15:0] vclick;
		logic [15:0] last_click;
		logic [15:0] virt_addr;
	} xreq_t;

	function automatic seg_entry_t row_entry(input row_t row, input logic [1:0] seg);
		seg_entry_t e;
		e = seg_entry_t'(row[int'(seg)*ENTRY_W +: ENTRY_W]);
		return e;
	endfunction

	function automatic logic [16:0] seg_end(input seg_entry_t e);
		return {1'b0, e.vbase} + {1'b0, e.len};
	endfunction

	function automatic logic [31:0] seg_pa(input seg_entry_t e, input logic [15:0] vaddr);
		return (32'(e.pbase) << CLICK_BITS) + 32'(vaddr) - (32'(e.vbase) << CLICK_BITS);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/sat_map_ram.sv =====
// Segment map memory: one row per slot, lane-wise write, registered read.
`default_nettype none
module sat_map_ram #(
	parameter int DEPTH  = 32,
	parameter int LANES  = 3,
	parameter int LANE_W = 48,
	parameter int AW     = $clog2(DEPTH)
) (
	input  wire logic                    clk,
	input  wire logic [AW-1:0]           addr,
	input  wire logic [LANES-1:0]        we,
	input  wire logic [LANES*LANE_W-1:0] wdata,
	input  wire logic                    re,
	output logic      [LANES*LANE_W-1:0] rdata
);

	logic [LANES*LANE_W-1:0] mem [DEPTH];
	logic [LANES*LANE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			if (we[l]) begin
				mem[addr][l*LANE_W +: LANE_W] <= wdata[l*LANE_W +: LANE_W];
			end
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/sat_xlate.sv =====
// Translate datapath: segment end and address terms, then select and fault check.
`default_nettype none
module sat_xlate (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire sat_pkg::xreq_t  xreq_s1,
	input  wire sat_pkg::row_t   row,
	output logic                 done,
	output logic [31:0]          phys_addr,
	output logic                 fault
);

	sat_pkg::seg_entry_t text_e, data_e, stack_e;

	logic        valid_s2;
	logic        fault_s2;
	logic        text_s2;
	logic [15:0] vclick_s2;
	logic [15:0] last_click_s2;
	logic [16:0] text_end_s2, data_end_s2, stack_end_s2;
	logic [31:0] text_pa_s2, data_pa_s2, stack_pa_s2;

	logic        use_data;
	logic [16:0] sel_end;
	logic [31:0] sel_pa;
	logic        flt;

	logic        done_q;
	logic        fault_q;
	logic [31:0] phys_addr_q;

	assign text_e  = sat_pkg::row_entry(row, sat_pkg::SEG_TEXT);
	assign data_e  = sat_pkg::row_entry(row, sat_pkg::SEG_DATA);
	assign stack_e = sat_pkg::row_entry(row, sat_pkg::SEG_STACK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= xreq_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (xreq_s1.valid) begin
			fault_s2      <= xreq_s1.fault;
			text_s2       <= xreq_s1.text;
			vclick_s2     <= xreq_s1.vclick;
			last_click_s2 <= xreq_s1.last_click;
			text_end_s2   <= sat_pkg::seg_end(text_e);
			data_end_s2   <= sat_pkg::seg_end(data_e);
			stack_end_s2  <= sat_pkg::seg_end(stack_e);
			text_pa_s2    <= sat_pkg::seg_pa(text_e, xreq_s1.virt_addr);
			data_pa_s2    <= sat_pkg::seg_pa(data_e, xreq_s1.virt_addr);
			stack_pa_s2   <= sat_pkg::seg_pa(stack_e, xreq_s1.virt_addr);
		end
	end

	always_comb begin
		use_data = ({1'b0, last_click_s2} < data_end_s2);
		if (text_s2) begin
			sel_end = text_end_s2;
			sel_pa  = text_pa_s2;
		end else if (use_data) begin
			sel_end = data_end_s2;
			sel_pa  = data_pa_s2;
		end else begin
			sel_end = stack_end_s2;
			sel_pa  = stack_pa_s2;
		end
		flt = fault_s2 || ({1'b0, vclick_s2} >= sel_end);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= 1'b0;
			fault_q <= 1'b0;
		end else begin
			done_q  <= valid_s2;
			fault_q <= valid_s2 && flt;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			phys_addr_q <= flt ? 32'd0 : sel_pa;
		end
	end

	assign done      = done_q;
	assign fault     = fault_q;
	assign phys_addr = phys_addr_q;

endmodule
`default_nettype wire

// ===== rtl/segment_address_translator_core.sv =====
// Top level of the segment address translator.
//
// Usage:
//   A request is taken on a rising edge with start high and busy low; kind
//   selects a map load (no result) or a translation (one result).
//   busy stays low: the block takes one request in every cycle.
//   A load writes one lane of the slot's row (none for segment code 3) in the
//   map memory at the edge that takes it; a translation in the next cycle already sees it.
//   A translation reads the whole slot row from the map memory into the read
//   register, forms segment ends and candidate addresses in the stage-two
//   registers, then selects the text, data or stack entry and checks the limit
//   into the result register.
//   done is high for one cycle with each result; phys_addr is zero on a fault.
//   Throughput is one request per cycle, set by the single map memory port.
//   The receiver cannot stall; results are not held.
//   Reset clears the first pipeline stage and the valid flags; the map
//   holds no defined value until each entry is loaded.
`default_nettype none
module segment_address_translator_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        kind,
	input  wire logic [4:0]  proc_slot,
	input  wire logic [1:0]  segment,
	input  wire logic [15:0] virt_addr,
	input  wire logic [15:0] byte_count,
	input  wire logic [15:0] map_vir_clicks,
	input  wire logic [15:0] map_len_clicks,
	input  wire logic [15:0] map_phys_clicks,
	output logic             done,
	output logic [31:0]      phys_addr,
	output logic             fault
);

	logic                accept;
	logic                slot_ok;
	logic                load_we;
	logic                xlate_re;
	sat_pkg::lane_t      lane_we;
	sat_pkg::seg_entry_t wentry;
	sat_pkg::row_t       wrow;
	sat_pkg::row_t       rrow;
	logic [15:0]         last_byte;
	sat_pkg::xreq_t      xreq_d;
	sat_pkg::xreq_t      xreq_s1;

	assign busy     = 1'b0;
	assign accept   = start && !busy;
	assign slot_ok  = int'(proc_slot) < sat_pkg::PROC_SLOTS;
	assign load_we  = accept && (kind == sat_pkg::KIND_LOAD) && slot_ok
		&& (int'(segment) < sat_pkg::NUM_SEGMENTS);
	assign xlate_re = accept && (kind == sat_pkg::KIND_XLATE);
	assign lane_we  = load_we ? (sat_pkg::lane_t'(1) << segment) : '0;

	assign wentry.vbase = map_vir_clicks;
	assign wentry.len   = map_len_clicks;
	assign wentry.pbase = map_phys_clicks;
	assign wrow         = {sat_pkg::NUM_SEGMENTS{wentry}};

	assign last_byte = virt_addr + byte_count - 16'd1;

	always_comb begin
		xreq_d.valid      = xlate_re;
		xreq_d.fault      = !slot_ok || (byte_count == 16'd0);
		xreq_d.text       = (segment == sat_pkg::SEG_TEXT);
		xreq_d.vclick     = virt_addr >> sat_pkg::CLICK_BITS;
		xreq_d.last_click = last_byte >> sat_pkg::CLICK_BITS;
		xreq_d.virt_addr  = virt_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xreq_s1 <= '0;
		end else if (xlate_re) begin
			xreq_s1 <= xreq_d;
		end else begin
			xreq_s1.valid <= 1'b0;
		end
	end

	sat_map_ram #(
		.DEPTH  (sat_pkg::PROC_SLOTS),
		.LANES  (sat_pkg::NUM_SEGMENTS),
		.LANE_W (sat_pkg::ENTRY_W)
	) u_map_ram (
		.clk   (clk),
		.addr  (sat_pkg::slot_t'(proc_slot)),
		.we    (lane_we),
		.wdata (wrow),
		.re    (xlate_re),
		.rdata (rrow)
	);

	sat_xlate u_xlate (
		.clk       (clk),
		.arst_n    (arst_n),
		.xreq_s1   (xreq_s1),
		.row       (rrow),
		.done      (done),
		.phys_addr (phys_addr),
		.fault     (fault)
	);

`ifndef SYNTHESIS
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		xreq_s1.valid |-> ##2 done)
		else $error("translate request lost in pipeline");

	a_result_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(xreq_s1.valid, 2))
		else $error("result without a translate request");

	a_early_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(xreq_s1.valid && xreq_s1.fault) |-> ##2 (done && fault))
		else $error("zero count or bad slot did not fault");

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && fault) |-> (phys_addr == 32'd0))
		else $error("faulting result carries an address");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the segment address translator core.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] SEG_CODE_SPARE = 2'd3;
	localparam int         CYCLE_LIMIT    = 400000;
	localparam int         RANDOM_ITEMS   = 1200;
	localparam int         MAX_REPORTS    = 10;

	typedef struct {
		logic [31:0] phys;
		logic        flt;
	} xlate_result_t;

	class xlate_scoreboard;
		sat_pkg::seg_entry_t seg_map [sat_pkg::PROC_SLOTS][sat_pkg::NUM_SEGMENTS];
		xlate_result_t       expected_xlations [$];
		int                  error_count = 0;

		function int pending();
			return expected_xlations.size();
		endfunction

		function void note_request(logic k, logic [4:0] slot, logic [1:0] seg,
				logic [15:0] va, logic [15:0] cnt, logic [15:0] mv,
				logic [15:0] ml, logic [15:0] mp);
			xlate_result_t       r;
			sat_pkg::seg_entry_t e;
			logic [1:0]          lane;
			logic [15:0]         last_byte;
			logic [16:0]         data_end;
			logic [16:0]         lane_end;
			if (k == sat_pkg::KIND_LOAD) begin
				if (seg != SEG_CODE_SPARE)
					seg_map[slot][seg] = '{vbase: mv, len: ml, pbase: mp};
				return;
			end
			r.phys = 32'd0;
			r.flt  = 1'b1;
			if (cnt != 16'd0) begin
				lane = seg;
				if (seg != sat_pkg::SEG_TEXT) begin
					last_byte = va + cnt - 16'd1;
					data_end  = {1'b0, seg_map[slot][sat_pkg::SEG_DATA].vbase} +
						{1'b0, seg_map[slot][sat_pkg::SEG_DATA].len};
					lane = (17'(last_byte >> sat_pkg::CLICK_BITS) < data_end) ?
						sat_pkg::SEG_DATA : sat_pkg::SEG_STACK;
				end
				e        = seg_map[slot][lane];
				lane_end = {1'b0, e.vbase} + {1'b0, e.len};
				if (17'(va >> sat_pkg::CLICK_BITS) < lane_end) begin
					r.phys = ({16'd0, e.pbase} << sat_pkg::CLICK_BITS) + {16'd0, va} -
						({16'd0, e.vbase} << sat_pkg::CLICK_BITS);
					r.flt  = 1'b0;
				end
			end
			expected_xlations.push_back(r);
		endfunction

		function void check_result(logic [31:0] pa, logic flt);
			xlate_result_t r;
			if (expected_xlations.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("ERROR: unexpected result phys_addr=%h fault=%b", pa, flt);
				return;
			end
			r = expected_xlations.pop_front();
			if (pa !== r.phys || flt !== r.flt) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("ERROR: expected phys_addr=%h fault=%b, got phys_addr=%h fault=%b",
						r.phys, r.flt, pa, flt);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        kind;
	logic [4:0]  proc_slot;
	logic [1:0]  segment;
	logic [15:0] virt_addr;
	logic [15:0] byte_count;
	logic [15:0] map_vir_clicks;
	logic [15:0] map_len_clicks;
	logic [15:0] map_phys_clicks;
	logic        done;
	logic [31:0] phys_addr;
	logic        fault;

	xlate_scoreboard sb;
	int              cycle_count = 0;

	segment_address_translator_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.kind            (kind),
		.proc_slot       (proc_slot),
		.segment         (segment),
		.virt_addr       (virt_addr),
		.byte_count      (byte_count),
		.map_vir_clicks  (map_vir_clicks),
		.map_len_clicks  (map_len_clicks),
		.map_phys_clicks (map_phys_clicks),
		.done            (done),
		.phys_addr       (phys_addr),
		.fault           (fault)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done === 1'b1)
				sb.check_result(phys_addr, fault);
			if (start && !busy)
				sb.note_request(kind, proc_slot, segment, virt_addr, byte_count,
					map_vir_clicks, map_len_clicks, map_phys_clicks);
		end
	end

	task automatic issue_request(input logic k, input logic [4:0] slot, input logic [1:0] seg,
			input logic [15:0] va, input logic [15:0] cnt, input logic [15:0] mv,
			input logic [15:0] ml, input logic [15:0] mp, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start           <= 1'b1;
		kind            <= k;
		proc_slot       <= slot;
		segment         <= seg;
		virt_addr       <= va;
		byte_count      <= cnt;
		map_vir_clicks  <= mv;
		map_len_clicks  <= ml;
		map_phys_clicks <= mp;
		do @(posedge clk); while (busy);
	endtask

	task automatic do_load(input logic [4:0] slot, input logic [1:0] seg, input logic [15:0] mv,
			input logic [15:0] ml, input logic [15:0] mp, input int gap);
		issue_request(sat_pkg::KIND_LOAD, slot, seg, 16'($urandom), 16'($urandom),
			mv, ml, mp, gap);
	endtask

	task automatic do_translate(input logic [4:0] slot, input logic [1:0] seg,
			input logic [15:0] va, input logic [15:0] cnt, input int gap);
		issue_request(sat_pkg::KIND_XLATE, slot, seg, va, cnt, 16'($urandom), 16'($urandom),
			16'($urandom), gap);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic sat_pkg::seg_entry_t random_entry(input logic [1:0] seg);
		sat_pkg::seg_entry_t e;
		e.pbase = 16'($urandom);
		if ($urandom_range(0, 7) == 0) begin
			e.vbase = 16'($urandom);
			e.len   = 16'($urandom);
		end else if (seg == sat_pkg::SEG_TEXT) begin
			e.vbase = 16'($urandom_range(0, 255));
			e.len   = 16'($urandom_range(0, 1024));
		end else if (seg == sat_pkg::SEG_DATA) begin
			e.vbase = 16'($urandom_range(0, 2048));
			e.len   = 16'($urandom_range(0, 1024));
		end else begin
			e.vbase = 16'($urandom_range(2048, 4095));
			e.len   = 16'($urandom_range(0, 2048));
		end
		return e;
	endfunction

	initial begin
		sat_pkg::seg_entry_t e;
		logic [4:0]          slot;
		logic [1:0]          seg;
		logic [1:0]          lane;
		logic [15:0]         va;
		logic [15:0]         cnt;
		int                  lo;
		int                  hi;
		int                  c;
		int                  pick;
		int                  gap;
		bit                  quiet;

		sb = new();
		arst_n          <= 1'b0;
		start           <= 1'b0;
		kind            <= sat_pkg::KIND_LOAD;
		proc_slot       <= 5'd0;
		segment         <= sat_pkg::SEG_TEXT;
		virt_addr       <= 16'd0;
		byte_count      <= 16'd0;
		map_vir_clicks  <= 16'd0;
		map_len_clicks  <= 16'd0;
		map_phys_clicks <= 16'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		do_load(5'd0, sat_pkg::SEG_TEXT, 16'd0, 16'd16, 16'h0100, 0);
		do_load(5'd0, sat_pkg::SEG_DATA, 16'd16, 16'd32, 16'hFFFF, 0);
		do_load(5'd0, sat_pkg::SEG_STACK, 16'd4000, 16'd96, 16'h0000, 0);
		do_load(5'd31, sat_pkg::SEG_TEXT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
		do_load(5'd31, sat_pkg::SEG_DATA, 16'hFFFF, 16'hFFFF, 16'h0000, 0);
		do_load(5'd31, sat_pkg::SEG_STACK, 16'h0000, 16'h0000, 16'h8000, 0);
		do_load(5'd31, SEG_CODE_SPARE, 16'h1234, 16'h0001, 16'h5678, 0);
		do_translate(5'd0, sat_pkg::SEG_TEXT, 16'h0000, 16'd1, 0);
		do_translate(5'd0, sat_pkg::SEG_TEXT, 16'h00FF, 16'd1, 0);
		do_translate(5'd0, sat_pkg::SEG_TEXT, 16'h0100, 16'd1, 0);
		do_translate(5'd0, sat_pkg::SEG_TEXT, 16'h0000, 16'd0, 0);
		do_translate(5'd0, sat_pkg::SEG_DATA, 16'h0100, 16'd16, 0);
		do_translate(5'd0, sat_pkg::SEG_DATA, 16'h02FF, 16'd1, 0);
		do_translate(5'd0, sat_pkg::SEG_DATA, 16'h0300, 16'd1, 0);
		do_translate(5'd0, sat_pkg::SEG_STACK, 16'hFFFF, 16'd1, 0);
		do_translate(5'd0, sat_pkg::SEG_STACK, 16'hFFF0, 16'h0020, 0);
		do_translate(5'd0, SEG_CODE_SPARE, 16'h0200, 16'hFFFF, 0);
		do_translate(5'd31, sat_pkg::SEG_TEXT, 16'hFFFF, 16'hFFFF, 0);
		do_translate(5'd31, sat_pkg::SEG_DATA, 16'h0000, 16'd1, 0);
		do_translate(5'd31, SEG_CODE_SPARE, 16'hFFFF, 16'd1, 0);
		do_translate(5'd31, sat_pkg::SEG_STACK, 16'h1234, 16'd0, 0);
		do_load(5'd0, sat_pkg::SEG_DATA, 16'd0, 16'd0, 16'd0, 0);
		do_translate(5'd0, sat_pkg::SEG_DATA, 16'h0000, 16'd1, 0);
		drain();

		for (int s = 0; s < sat_pkg::PROC_SLOTS; s++) begin
			for (int g = 0; g < sat_pkg::NUM_SEGMENTS; g++) begin
				e = random_entry(2'(g));
				do_load(5'(s), 2'(g), e.vbase, e.len, e.pbase, $urandom_range(0, 3));
			end
		end

		quiet = 1'b0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 64 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			if (i % 300 == 150)
				drain();
			gap = quiet ? 0 : $urandom_range(0, 14);
			slot = 5'($urandom_range(0, sat_pkg::PROC_SLOTS - 1));
			seg  = 2'($urandom_range(0, 3));
			if ($urandom_range(0, 9) == 0) begin
				e = random_entry(seg);
				do_load(slot, seg, e.vbase, e.len, e.pbase, gap);
			end else begin
				if (seg == sat_pkg::SEG_TEXT)
					lane = sat_pkg::SEG_TEXT;
				else
					lane = $urandom_range(0, 1) ? sat_pkg::SEG_DATA : sat_pkg::SEG_STACK;
				e    = sb.seg_map[slot][lane];
				lo   = int'(e.vbase);
				hi   = lo + int'(e.len);
				pick = $urandom_range(0, 9);
				if (pick < 2)
					c = hi;
				else if (pick == 2)
					c = hi - 1;
				else
					c = $urandom_range(lo, hi);
				va = {c[11:0], 4'($urandom)};
				if (pick == 9)
					va = 16'($urandom);
				pick = $urandom_range(0, 15);
				if (pick == 0)
					cnt = 16'd0;
				else if (pick < 4)
					cnt = 16'($urandom);
				else if (pick == 4)
					cnt = 16'hFFFF;
				else
					cnt = 16'($urandom_range(1, 64));
				do_translate(slot, seg, va, cnt, gap);
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (sb.error_count == 0 && sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/sat_pkg.sv
rtl/sat_map_ram.sv
rtl/sat_xlate.sv
rtl/segment_address_translator_core.sv
tb/tb_top.sv
